>>> hdl/ps2pt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2pt_pkg: shared types and constants for the PS/2 mouse packet tracker
// Command format passed from the byte gatherer to the state updater.
// ----------------------------------------------------------------------------
package ps2pt_pkg;

    localparam int POS_W   = 12;
    localparam int WHEEL_W = 16;
    localparam int BTN_W   = 3;

    localparam int SYNC_BIT_IDX = 3;  // first byte must carry this bit
    localparam int OVF_X_IDX    = 6;
    localparam int OVF_Y_IDX    = 7;

    localparam logic [POS_W-1:0]   POS_MAX   = 12'd4095;
    localparam logic [WHEEL_W-1:0] WHEEL_MAX = 16'h7FFF;
    localparam logic [WHEEL_W-1:0] WHEEL_MIN = 16'h8000;

    localparam logic [1:0] BPOS_FIRST = 2'd0;
    localparam logic [1:0] BPOS_THIRD = 2'd2;
    localparam logic [1:0] BPOS_FOURTH = 2'd3;

    typedef enum logic [1:0] {
        CMD_SHOW  = 2'd0,   // no state change, report current state
        CMD_LOAD  = 2'd1,   // load cursor position
        CMD_APPLY = 2'd2    // packet complete, apply it
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic              wheel_on;
        logic [7:0]        b0;
        logic [7:0]        b1;
        logic [7:0]        b2;
        logic [7:0]        b3;
        logic [POS_W-1:0]  new_x;
        logic [POS_W-1:0]  new_y;
    } cmd_t;

endpackage : ps2pt_pkg
`default_nettype wire

>>> hdl/ps2pt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2pt_front: byte gatherer
// Tracks packet position, stores bytes and emits one command per transfer.
// ----------------------------------------------------------------------------
module ps2pt_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_wdata,
    input  wire logic                         s_fire,
    input  wire logic                         s_kind,
    input  wire logic [7:0]                   s_data_byte,
    input  wire logic [ps2pt_pkg::POS_W-1:0]  s_new_x,
    input  wire logic [ps2pt_pkg::POS_W-1:0]  s_new_y,
    output ps2pt_pkg::cmd_t                   cmd
);
    import ps2pt_pkg::*;

    logic       wheel_en_reg;
    logic [1:0] bpos_reg, bpos_next;
    logic [7:0] pkt_reg [3];
    logic       store_en;
    logic [1:0] last_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_en_reg <= 1'b0;
        end else if (cfg_we) begin
            wheel_en_reg <= cfg_wdata;
        end
    end

    always_comb begin
        last_pos  = wheel_en_reg ? BPOS_FOURTH : BPOS_THIRD;
        bpos_next = bpos_reg;
        store_en  = 1'b0;
        cmd.op       = CMD_SHOW;
        cmd.wheel_on = wheel_en_reg;
        cmd.b0       = pkt_reg[0];
        cmd.b1       = pkt_reg[1];
        cmd.b2       = (bpos_reg == BPOS_THIRD) ? s_data_byte : pkt_reg[2];
        cmd.b3       = (bpos_reg == BPOS_FOURTH) ? s_data_byte : 8'h00;
        cmd.new_x    = s_new_x;
        cmd.new_y    = s_new_y;
        if (s_kind) begin
            cmd.op = CMD_LOAD;
        end else if (bpos_reg == BPOS_FIRST) begin
            // drop bytes without the sync bit to regain alignment
            if (s_data_byte[SYNC_BIT_IDX]) begin
                store_en  = 1'b1;
                bpos_next = 2'd1;
            end
        end else if (bpos_reg < last_pos) begin
            store_en  = 1'b1;
            bpos_next = bpos_reg + 2'd1;
        end else begin
            cmd.op    = CMD_APPLY;
            bpos_next = BPOS_FIRST;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpos_reg <= BPOS_FIRST;
        end else if (s_fire) begin
            bpos_reg <= bpos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && store_en) begin
            pkt_reg[bpos_reg] <= s_data_byte;
        end
    end

    a_apply_resets_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && cmd.op == CMD_APPLY) |=> (bpos_reg == BPOS_FIRST))
        else $error("packet position not reset after apply");

    a_unsynced_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_kind && bpos_reg == BPOS_FIRST && !s_data_byte[SYNC_BIT_IDX])
        |=> (bpos_reg == BPOS_FIRST))
        else $error("byte without sync bit started a packet");

endmodule : ps2pt_front
`default_nettype wire

>>> hdl/ps2pt_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2pt_queue: command queue
// Small register FIFO between the byte gatherer and the state updater.
// ----------------------------------------------------------------------------
module ps2pt_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire ps2pt_pkg::cmd_t push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output ps2pt_pkg::cmd_t      pop_cmd
);
    import ps2pt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          q_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)      count_reg <= count_reg + CW'(1);
            else if (pop && !push) count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full) && !(pop && !not_empty))
        else $error("command queue overflow or underflow");

endmodule : ps2pt_queue
`default_nettype wire

>>> hdl/ps2pt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ps2pt_back: state updater
// Applies commands to cursor, wheel and buttons; state registers drive outputs.
// ----------------------------------------------------------------------------
module ps2pt_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           q_valid,
    input  wire ps2pt_pkg::cmd_t                q_cmd,
    output logic                                q_pop,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [ps2pt_pkg::POS_W-1:0]         m_cursor_x,
    output logic [ps2pt_pkg::POS_W-1:0]         m_cursor_y,
    output logic signed [ps2pt_pkg::WHEEL_W-1:0] m_wheel_count,
    output logic [ps2pt_pkg::BTN_W-1:0]         m_buttons,
    output logic                                m_packet_applied
);
    import ps2pt_pkg::*;

    logic               valid_reg;
    logic               applied_reg;
    logic [POS_W-1:0]   x_reg, x_next;
    logic [POS_W-1:0]   y_reg, y_next;
    logic [WHEEL_W-1:0] wheel_reg, wheel_next;
    logic [BTN_W-1:0]   btn_reg, btn_next;
    logic [POS_W+1:0]   sum_x, sum_y;
    logic [3:0]         nib;

    function automatic logic [POS_W-1:0] clamp(input logic [POS_W+1:0] v);
        if (v[POS_W+1])    return '0;
        else if (v[POS_W]) return POS_MAX;
        else               return v[POS_W-1:0];
    endfunction

    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        sum_x = {2'b00, x_reg} + {{6{q_cmd.b1[7]}}, q_cmd.b1};
        sum_y = {2'b00, y_reg} - {{6{q_cmd.b2[7]}}, q_cmd.b2};
        nib   = q_cmd.b3[3:0];
        x_next     = x_reg;
        y_next     = y_reg;
        wheel_next = wheel_reg;
        btn_next   = btn_reg;
        case (q_cmd.op)
            CMD_LOAD: begin
                x_next = q_cmd.new_x;
                y_next = q_cmd.new_y;
            end
            CMD_APPLY: begin
                btn_next = q_cmd.b0[BTN_W-1:0];
                if (!q_cmd.b0[OVF_X_IDX] && !q_cmd.b0[OVF_Y_IDX]) begin
                    x_next = clamp(sum_x);
                    y_next = clamp(sum_y);
                end
                if (q_cmd.wheel_on && nib != 4'd0) begin
                    if (nib[3]) begin
                        if (wheel_reg != WHEEL_MIN) wheel_next = wheel_reg - 16'd1;
                    end else begin
                        if (wheel_reg != WHEEL_MAX) wheel_next = wheel_reg + 16'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            applied_reg <= 1'b0;
            x_reg       <= '0;
            y_reg       <= '0;
            wheel_reg   <= '0;
            btn_reg     <= '0;
        end else begin
            if (q_pop) begin
                valid_reg   <= 1'b1;
                applied_reg <= (q_cmd.op == CMD_APPLY);
                x_reg       <= x_next;
                y_reg       <= y_next;
                wheel_reg   <= wheel_next;
                btn_reg     <= btn_next;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = valid_reg;
    assign m_cursor_x       = x_reg;
    assign m_cursor_y       = y_reg;
    assign m_wheel_count    = signed'(wheel_reg);
    assign m_buttons        = btn_reg;
    assign m_packet_applied = applied_reg;

    a_show_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_cmd.op == CMD_SHOW)
        |=> ($stable(x_reg) && $stable(y_reg) && $stable(wheel_reg) && $stable(btn_reg)))
        else $error("non-completing byte changed tracker state");

    a_wheel_step: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> ((wheel_reg - $past(wheel_reg)) == 16'd0 ||
                   (wheel_reg - $past(wheel_reg)) == 16'd1 ||
                   (wheel_reg - $past(wheel_reg)) == 16'hFFFF))
        else $error("wheel count moved by more than one notch");

endmodule : ps2pt_back
`default_nettype wire

>>> hdl/ps2_mouse_packet_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An item transferred on s_* is first written into the command queue, then popped by the
//   state updater, which applies it to the output/state register that drives m_*.
// Throughput: one item per cycle unless the 4-entry queue is full; it absorbs output stalls.
// Reset: synchronous active-low aresetn clears packet position, cursor, wheel count,
//   buttons, wheel_enabled and all valid/queue state; stored packet bytes are not cleared.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit: PS/2 mouse packet decoder top level
// Gathers 3- or 4-byte mouse packets and tracks a clamped cursor, button
// state and a saturating wheel count. One result per input transfer.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // wheel_enabled register write port
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_wdata,
    // input items
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_kind,
    input  wire logic [7:0]                      s_data_byte,
    input  wire logic [ps2pt_pkg::POS_W-1:0]     s_new_x,
    input  wire logic [ps2pt_pkg::POS_W-1:0]     s_new_y,
    // results
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [ps2pt_pkg::POS_W-1:0]          m_cursor_x,
    output logic [ps2pt_pkg::POS_W-1:0]          m_cursor_y,
    output logic signed [ps2pt_pkg::WHEEL_W-1:0] m_wheel_count,
    output logic [ps2pt_pkg::BTN_W-1:0]          m_buttons,
    output logic                                 m_packet_applied
);
    import ps2pt_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_full;
    logic queue_not_empty;
    logic queue_pop;
    logic s_fire;

    // Input side only waits on queue space, never on the output side directly.
    assign s_ready = !queue_full;
    assign s_fire  = s_valid && s_ready;

    // Front: tracks byte position and classifies each transfer into a command.
    ps2pt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_fire      (s_fire),
        .s_kind      (s_kind),
        .s_data_byte (s_data_byte),
        .s_new_x     (s_new_x),
        .s_new_y     (s_new_y),
        .cmd         (front_cmd)
    );

    // Decouples the gatherer from result back-pressure.
    ps2pt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_fire),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_cmd   (queue_cmd)
    );

    // Back: applies commands to cursor/wheel/buttons; its state is the output.
    ps2pt_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (queue_not_empty),
        .q_cmd            (queue_cmd),
        .q_pop            (queue_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_x       (m_cursor_x),
        .m_cursor_y       (m_cursor_y),
        .m_wheel_count    (m_wheel_count),
        .m_buttons        (m_buttons),
        .m_packet_applied (m_packet_applied)
    );

endmodule : ps2_mouse_packet_tracker_unit
`default_nettype wire
